>>> src/tcp_segment_reassembly_tracker_macros.svh
// Assertion macros for the tracker's top-level RTL file.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef TCP_SEGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define TCP_SEGMENT_REASSEMBLY_TRACKER_MACROS_SVH

`define TSRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

`define TSRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

>>> src/tsrt_pkg.sv
// Package of the TCP reassembly tracker: sizes, result codes, register indexes
// and the command and status types between controller and datapath. No dependencies.
package tsrt_pkg;

    localparam int MaxFrags = 16;
    localparam int IdxW     = $clog2(MaxFrags);
    localparam int CntW     = $clog2(MaxFrags + 1);
    localparam int SeqW     = 32;
    localparam int LenW     = 21;
    localparam int InW      = 56;
    localparam int OutW     = 80;

    localparam logic [SeqW-1:0] SeqTop   = 32'h8000_0000;
    localparam logic [LenW-1:0] BufReset = 21'd8192;

    localparam logic CfgBufSize = 1'b0;
    localparam logic CfgInitSeq = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OLD   = 2'd1,
        ST_NOFIT = 2'd2,
        ST_FULL  = 2'd3
    } res_code_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CHECK,
        CMD_SCAN,
        CMD_MERGE,
        CMD_SHIFT_DN,
        CMD_DN_END,
        CMD_UP_INIT,
        CMD_SHIFT_UP,
        CMD_PLACE,
        CMD_HEAD,
        CMD_RM_TRIM,
        CMD_RM_SHIFT,
        CMD_RM_END,
        CMD_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        res_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic            is_rm;
        logic            zero_len;
        logic            old;
        logic            nofit;
        logic            scan_done;
        logic            found;
        logic            full;
        logic            dn_done;
        logic            up_done;
        logic            req_zero;
        logic            rm_whole;
        logic            rmsh_done;
        logic            out_free;
        logic            rdbl_nz;
        logic [CntW-1:0] cnt;
    } dp_stat_t;

endpackage

>>> src/tsrt_ctrl.sv
// Controller of the reassembly tracker: sequences checks, table scans and shifts.
// Depends on tsrt_pkg; drives the datapath with one command per cycle.
module tsrt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tsrt_pkg::dp_stat_t st,
    output tsrt_pkg::dp_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CHECK   = 9'b000000010,
        S_SCAN    = 9'b000000100,
        S_SHDN    = 9'b000001000,
        S_SHUP    = 9'b000010000,
        S_HEAD    = 9'b000100000,
        S_RMTRIM  = 9'b001000000,
        S_RMSHIFT = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    tsrt_pkg::res_code_t  code_reg, code_next;
    tsrt_pkg::dp_op_t     op_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= tsrt_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        op_sel     = tsrt_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_sel     = tsrt_pkg::CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                op_sel    = tsrt_pkg::CMD_CHECK;
                code_next = tsrt_pkg::ST_OK;
                priority if (st.is_rm) begin
                    state_next = st.req_zero ? S_DONE : S_RMTRIM;
                end else if (st.zero_len) begin
                    state_next = S_DONE;
                end else if (st.old) begin
                    code_next  = tsrt_pkg::ST_OLD;
                    state_next = S_DONE;
                end else if (st.nofit) begin
                    code_next  = tsrt_pkg::ST_NOFIT;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (!st.scan_done) begin
                    op_sel = tsrt_pkg::CMD_SCAN;
                end else if (st.found) begin
                    op_sel     = tsrt_pkg::CMD_MERGE;
                    state_next = S_SHDN;
                end else if (st.full) begin
                    code_next  = tsrt_pkg::ST_FULL;
                    state_next = S_DONE;
                end else begin
                    op_sel     = tsrt_pkg::CMD_UP_INIT;
                    state_next = S_SHUP;
                end
            end
            S_SHDN: begin
                if (!st.dn_done) begin
                    op_sel = tsrt_pkg::CMD_SHIFT_DN;
                end else begin
                    op_sel     = tsrt_pkg::CMD_DN_END;
                    state_next = S_HEAD;
                end
            end
            S_SHUP: begin
                if (!st.up_done) begin
                    op_sel = tsrt_pkg::CMD_SHIFT_UP;
                end else begin
                    op_sel     = tsrt_pkg::CMD_PLACE;
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                op_sel     = tsrt_pkg::CMD_HEAD;
                state_next = S_DONE;
            end
            S_RMTRIM: begin
                op_sel     = tsrt_pkg::CMD_RM_TRIM;
                state_next = st.rm_whole ? S_RMSHIFT : S_DONE;
            end
            S_RMSHIFT: begin
                if (!st.rmsh_done) begin
                    op_sel = tsrt_pkg::CMD_RM_SHIFT;
                end else begin
                    op_sel     = tsrt_pkg::CMD_RM_END;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    op_sel     = tsrt_pkg::CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.op   = op_sel;
    assign cmd.code = code_reg;

endmodule

>>> src/tsrt_dpath.sv
// Datapath of the reassembly tracker: fragment table, head, counters and result register.
// Depends on tsrt_pkg; executes the commands of tsrt_ctrl.
module tsrt_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsrt_pkg::dp_cmd_t             cmd,
    output tsrt_pkg::dp_stat_t            st,
    input  logic                          in_op,
    input  logic [tsrt_pkg::SeqW-1:0]     in_seq,
    input  logic [tsrt_pkg::LenW-1:0]     in_len,
    input  logic                          cfg_we,
    input  logic                          cfg_idx,
    input  logic [tsrt_pkg::SeqW-1:0]     cfg_val,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [tsrt_pkg::LenW-1:0]     out_count,
    output logic [tsrt_pkg::LenW-1:0]     out_readable,
    output logic [tsrt_pkg::SeqW-1:0]     out_total
);

    localparam int IW = tsrt_pkg::IdxW;
    localparam int CW = tsrt_pkg::CntW;
    localparam int SW = tsrt_pkg::SeqW;
    localparam int LW = tsrt_pkg::LenW;

    logic [SW-1:0] start_reg [tsrt_pkg::MaxFrags];
    logic [LW-1:0] flen_reg  [tsrt_pkg::MaxFrags];

    logic [SW-1:0] head_reg, deliv_reg, seq_reg, d_reg, fo_reg, le_reg;
    logic [LW-1:0] buf_reg, len_reg, rdbl_reg, req_reg;
    logic [LW:0]   e_reg;
    logic          op_reg, gt_reg, found_reg, posf_reg;
    logic [CW-1:0] cnt_reg, idx_reg, pos_reg;
    logic [IW-1:0] first_reg, last_reg;

    logic          ov_reg;
    logic [1:0]    os_reg;
    logic [LW-1:0] oc_reg, or_reg;
    logic [SW-1:0] ot_reg;

    logic [IW-1:0] gap;
    logic [CW-1:0] rd_idx;
    logic [SW-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic [SW-1:0] o_off, oe_off, s32, e32, ns, ne;
    logic          touch;
    logic          we;
    logic [IW-1:0] wa;
    logic [SW-1:0] wd_start;
    logic [LW-1:0] wd_len;
    logic [LW-1:0] req_trim;

    assign gap      = last_reg - first_reg;
    assign s32      = {{(SW-LW){1'b0}}, d_reg[LW-1:0]};
    assign e32      = {{(SW-LW-1){1'b0}}, e_reg};
    assign rd_start = start_reg[rd_idx[IW-1:0]];
    assign rd_len   = flen_reg[rd_idx[IW-1:0]];
    assign o_off    = rd_start - head_reg;
    assign oe_off   = o_off + {{(SW-LW){1'b0}}, rd_len};
    assign touch    = (o_off <= e32) && (oe_off >= s32);
    assign ns       = (fo_reg < s32) ? fo_reg : s32;
    assign ne       = (le_reg > e32) ? le_reg : e32;
    assign req_trim = (req_reg > rd_len) ? rd_len : req_reg;

    always_comb begin
        unique case (cmd.op)
            tsrt_pkg::CMD_SHIFT_DN: rd_idx = idx_reg + CW'(gap);
            tsrt_pkg::CMD_SHIFT_UP: rd_idx = idx_reg - CW'(1);
            tsrt_pkg::CMD_RM_SHIFT: rd_idx = idx_reg + CW'(1);
            tsrt_pkg::CMD_HEAD,
            tsrt_pkg::CMD_RM_TRIM:  rd_idx = '0;
            default:                rd_idx = idx_reg;
        endcase
    end

    always_comb begin
        we       = 1'b0;
        wa       = idx_reg[IW-1:0];
        wd_start = rd_start;
        wd_len   = rd_len;
        unique case (cmd.op)
            tsrt_pkg::CMD_MERGE: begin
                we       = 1'b1;
                wa       = first_reg;
                wd_start = head_reg + ns;
                wd_len   = LW'(ne - ns);
            end
            tsrt_pkg::CMD_SHIFT_DN,
            tsrt_pkg::CMD_SHIFT_UP,
            tsrt_pkg::CMD_RM_SHIFT: begin
                we = 1'b1;
            end
            tsrt_pkg::CMD_PLACE: begin
                we       = 1'b1;
                wa       = pos_reg[IW-1:0];
                wd_start = seq_reg;
                wd_len   = len_reg;
            end
            tsrt_pkg::CMD_RM_TRIM: begin
                we       = (req_reg < rd_len);
                wa       = '0;
                wd_start = rd_start + {{(SW-LW){1'b0}}, req_trim};
                wd_len   = rd_len - req_trim;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            start_reg[wa] <= wd_start;
            flen_reg[wa]  <= wd_len;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            tsrt_pkg::CMD_LOAD: begin
                op_reg    <= in_op;
                seq_reg   <= in_seq;
                len_reg   <= in_len;
                d_reg     <= in_seq - head_reg;
                gt_reg    <= (in_seq > head_reg);
                idx_reg   <= '0;
                found_reg <= 1'b0;
                posf_reg  <= 1'b0;
                pos_reg   <= cnt_reg;
                req_reg   <= (in_len > rdbl_reg) ? rdbl_reg : in_len;
            end
            tsrt_pkg::CMD_CHECK: begin
                e_reg <= {1'b0, d_reg[LW-1:0]} + {1'b0, len_reg};
            end
            tsrt_pkg::CMD_SCAN: begin
                if (touch) begin
                    if (!found_reg) begin
                        first_reg <= idx_reg[IW-1:0];
                        fo_reg    <= o_off;
                    end
                    found_reg <= 1'b1;
                    last_reg  <= idx_reg[IW-1:0];
                    le_reg    <= oe_off;
                end
                if (!posf_reg && (o_off > s32)) begin
                    posf_reg <= 1'b1;
                    pos_reg  <= idx_reg;
                end
                idx_reg <= idx_reg + CW'(1);
            end
            tsrt_pkg::CMD_MERGE:    idx_reg <= CW'(first_reg) + CW'(1);
            tsrt_pkg::CMD_SHIFT_DN: idx_reg <= idx_reg + CW'(1);
            tsrt_pkg::CMD_UP_INIT:  idx_reg <= cnt_reg;
            tsrt_pkg::CMD_SHIFT_UP: idx_reg <= idx_reg - CW'(1);
            tsrt_pkg::CMD_RM_TRIM: begin
                req_reg <= req_trim;
                idx_reg <= '0;
            end
            tsrt_pkg::CMD_RM_SHIFT: idx_reg <= idx_reg + CW'(1);
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            buf_reg   <= tsrt_pkg::BufReset;
            cnt_reg   <= '0;
            rdbl_reg  <= '0;
            deliv_reg <= '0;
        end else begin
            unique case (cmd.op)
                tsrt_pkg::CMD_DN_END: cnt_reg <= cnt_reg - CW'(gap);
                tsrt_pkg::CMD_PLACE:  cnt_reg <= cnt_reg + CW'(1);
                tsrt_pkg::CMD_RM_END: cnt_reg <= cnt_reg - CW'(1);
                tsrt_pkg::CMD_HEAD: begin
                    if ((cnt_reg != '0) && (rd_start == head_reg)) begin
                        deliv_reg <= deliv_reg + {{(SW-LW){1'b0}}, rd_len - rdbl_reg};
                        rdbl_reg  <= rd_len;
                    end
                end
                tsrt_pkg::CMD_RM_TRIM: begin
                    head_reg <= head_reg + {{(SW-LW){1'b0}}, req_trim};
                    rdbl_reg <= rdbl_reg - req_trim;
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (cfg_we) begin
                if (cfg_idx == tsrt_pkg::CfgBufSize) begin
                    buf_reg <= cfg_val[LW-1:0];
                end else begin
                    head_reg  <= cfg_val;
                    cnt_reg   <= '0;
                    rdbl_reg  <= '0;
                    deliv_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.op == tsrt_pkg::CMD_RESULT) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == tsrt_pkg::CMD_RESULT) begin
            os_reg <= cmd.code;
            if (op_reg) begin
                oc_reg <= req_reg;
            end else begin
                oc_reg <= (cmd.code == tsrt_pkg::ST_OK) ? len_reg : '0;
            end
            or_reg <= rdbl_reg;
            ot_reg <= deliv_reg;
        end
    end

    assign st.is_rm     = op_reg;
    assign st.zero_len  = (len_reg == '0);
    assign st.old       = (d_reg > tsrt_pkg::SeqTop) || ((d_reg == tsrt_pkg::SeqTop) && gt_reg);
    assign st.nofit     = (d_reg > {{(SW-LW){1'b0}}, buf_reg})
                          || (len_reg > (buf_reg - d_reg[LW-1:0]));
    assign st.scan_done = (idx_reg == cnt_reg);
    assign st.found     = found_reg;
    assign st.full      = (cnt_reg == CW'(tsrt_pkg::MaxFrags));
    assign st.dn_done   = ({1'b0, idx_reg} + {1'b0, CW'(gap)}) >= {1'b0, cnt_reg};
    assign st.up_done   = (idx_reg <= pos_reg);
    assign st.req_zero  = (req_reg == '0) || (cnt_reg == '0);
    assign st.rm_whole  = (req_reg >= rd_len);
    assign st.rmsh_done = ({1'b0, idx_reg} + {{CW{1'b0}}, 1'b1}) >= {1'b0, cnt_reg};
    assign st.out_free  = !ov_reg || out_ready;
    assign st.rdbl_nz   = (rdbl_reg != '0);
    assign st.cnt       = cnt_reg;

    assign out_valid    = ov_reg;
    assign out_status   = os_reg;
    assign out_count    = oc_reg;
    assign out_readable = or_reg;
    assign out_total    = ot_reg;

endmodule

>>> src/tcp_segment_reassembly_tracker.sv
// An empty, old or out-of-window insert goes from the check straight to the result; a full
// table is found by a scan of the stored fragments; an accepted insert scans, then merges and
// shifts entries down or shifts entries up and places the fragment, then updates the head; a
// remove trims the first fragment and, if that fragment is used up, shifts the table down.
// One request is in work at a time: the next is taken once the tracker is idle after the result is registered.
// Reset (synchronous, aresetn low): empty table, head 0, window 8192, counters zero.
module tcp_segment_reassembly_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsrt_pkg::InW-1:0]      s_tdata,   // seq[31:0], length[52:32], zero pad
    input  logic                          s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsrt_pkg::OutW-1:0]     m_tdata,   // status, byte_count, readable,
                                                     // total_delivered, zero pad
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [tsrt_pkg::SeqW-1:0]     cfg_data
);

    `include "tcp_segment_reassembly_tracker_macros.svh"

    tsrt_pkg::dp_cmd_t  cmd;
    tsrt_pkg::dp_stat_t st;

    logic [1:0]                  o_status;
    logic [tsrt_pkg::LenW-1:0]   o_count, o_readable;
    logic [tsrt_pkg::SeqW-1:0]   o_total;

    assign cfg_ready = 1'b1;

    tsrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tsrt_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .in_op        (s_tuser),
        .in_seq       (s_tdata[31:0]),
        .in_len       (s_tdata[52:32]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_idx      (cfg_index),
        .cfg_val      (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (o_status),
        .out_count    (o_count),
        .out_readable (o_readable),
        .out_total    (o_total)
    );

    assign m_tdata = {4'b0, o_total, o_readable, o_count, o_status};

    `TSRT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    `TSRT_ASSERT_IMP(a_cnt_range, 1'b1, st.cnt <= tsrt_pkg::CntW'(tsrt_pkg::MaxFrags))
    `TSRT_ASSERT_IMP(a_rdbl_needs_frag, st.cnt == '0, !st.rdbl_nz)

endmodule
